FILE: hdl/urlpd_pkg.sv
// Shared constants and types for the URL percent decoder.
package urlpd_pkg;

  localparam int MAX_OUT = 3;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);
  localparam int IDX_W   = $clog2(MAX_OUT);
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
    logic                    last;
  } cmd_t;

endpackage

FILE: hdl/urlpd_front.sv
// Front end: accepts encoded bytes, tracks the escape state and builds output commands.
module urlpd_front import urlpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  localparam logic [1:0] PH_NONE    = 2'd0;
  localparam logic [1:0] PH_PERCENT = 2'd1;
  localparam logic [1:0] PH_DIGIT   = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] held_char;
  logic [3:0] held_value;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic [7:0] code;

  function automatic cmd_t put_byte(cmd_t c, logic [7:0] b);
    cmd_t r;
    r = c;
    if (c.cnt < CNT_W'(MAX_OUT)) begin
      r.bytes[c.cnt[IDX_W-1:0]] = b;
      r.cnt = c.cnt + CNT_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign code = {held_value, hex_val};

  always_comb begin
    logic plain;
    plain      = 1'b0;
    cmd        = '0;
    phase_next = PH_NONE;
    unique case (phase)
      PH_PERCENT: begin
        if (hex_ok) begin
          phase_next = PH_DIGIT;
        end else begin
          cmd   = put_byte(cmd, CH_PERCENT);
          plain = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (hex_ok && code != 8'd0) begin
          cmd = put_byte(cmd, code);
        end else begin
          cmd   = put_byte(cmd, CH_PERCENT);
          cmd   = put_byte(cmd, held_char);
          plain = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase
    if (plain) begin
      if (in_byte == CH_PERCENT) begin
        phase_next = PH_PERCENT;
      end else if (in_byte == CH_PLUS) begin
        cmd = put_byte(cmd, CH_SPACE);
      end else begin
        cmd = put_byte(cmd, in_byte);
      end
    end
    if (in_last) begin
      if (phase_next == PH_PERCENT) begin
        cmd = put_byte(cmd, CH_PERCENT);
      end else if (phase_next == PH_DIGIT) begin
        cmd = put_byte(cmd, CH_PERCENT);
        cmd = put_byte(cmd, in_byte);
      end
      phase_next = PH_NONE;
      cmd.last   = 1'b1;
    end
  end

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid && (cmd.cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NONE;
    end else if (in_valid && in_ready) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && phase == PH_PERCENT && hex_ok) begin
      held_char  <= in_byte;
      held_value <= hex_val;
    end
  end

endmodule

FILE: hdl/urlpd_queue.sv
// Short command queue between the front end and the output serialiser.
module urlpd_queue import urlpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: hdl/urlpd_back.sv
// Back end: sends the bytes of each queued command out one beat at a time.
module urlpd_back import urlpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [IDX_W-1:0] idx;
  logic             final_byte;

  assign final_byte = (CNT_W'(idx) == cmd.cnt - CNT_W'(1));
  assign out_valid  = cmd_valid;
  assign out_byte   = cmd.bytes[idx];
  assign out_last   = cmd.last && final_byte;
  assign cmd_ready  = out_ready && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= final_byte ? '0 : idx + IDX_W'(1);
    end
  end

endmodule

FILE: hdl/url_percent_decoder.sv
// Top level of the streaming form-urlencoded query string decoder.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_byte, in_last
//   out      output     out_valid / out_ready out_byte, out_last
//
// The front end takes one encoded byte per cycle while the two-entry command queue has room.
// The back end sends one decoded byte per cycle while out_ready is high, and a failed escape
// that gives up to three results holds its queue entry until all of them are sent.
// Results are registered in the command queue between the front end and the back end.
// Reset clears the escape state, the queue and the back-end byte index.
module url_percent_decoder import urlpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic b_valid;
  logic b_ready;
  cmd_t b_cmd;

  urlpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  urlpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  urlpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
